@@ rtl/fioe_pkg.sv @@
// Shared types, constants and the microcode table of the fade-in/out envelope.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package fioe_pkg;

    localparam int PC_BITS = 5;
    typedef logic [PC_BITS-1:0] pc_t;

    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [31:0] FRAME_NONE   = 32'hFFFF_FFFF;
    localparam logic [15:0] SHADOW_RESET = 16'hFFFF;
    localparam logic        OP_ARM       = 1'b0;

    localparam logic [2:0] REG_RISE     = 3'd0;
    localparam logic [2:0] REG_FALL     = 3'd1;
    localparam logic [2:0] REG_MODE     = 3'd2;
    localparam logic [2:0] REG_RANGE    = 3'd3;
    localparam logic [2:0] REG_MIN      = 3'd4;
    localparam logic [2:0] REG_AMBIENT  = 3'd5;
    localparam logic [2:0] REG_DIFFUSE  = 3'd6;
    localparam logic [2:0] REG_SHADOW   = 3'd7;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_ARM,
        UOP_COUNT,
        UOP_DIV,
        UOP_LEVEL
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ARM,
        COND_SKIP,
        COND_END,
        COND_KNOWN,
        COND_DIV_MORE
    } cond_t;

    typedef enum logic [2:0] {
        SRC_RANGE,
        SRC_AMB_R,
        SRC_AMB_G,
        SRC_AMB_B,
        SRC_DIF_R,
        SRC_DIF_G,
        SRC_DIF_B,
        SRC_SHADOW
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_RANGE,
        DST_AMB_R,
        DST_AMB_G,
        DST_AMB_B,
        DST_DIF_R,
        DST_DIF_G,
        DST_DIF_B,
        DST_SHADOW
    } dst_t;

    typedef struct packed {
        uop_t uop;
        src_t src;
        dst_t dst;
        logic emit;
        logic changed;
    } ctl_t;

    typedef struct packed {
        cond_t cond;
        pc_t   target;
        ctl_t  ctl;
    } uword_t;

    typedef struct packed {
        logic arm;
        logic skip;
        logic fin;
        logic known;
        logic div_more;
    } stat_t;

    typedef struct packed {
        logic        running;
        logic [16:0] level;
        logic [15:0] range_now;
        logic [15:0] amb_red;
        logic [15:0] amb_green;
        logic [15:0] amb_blue;
        logic [15:0] dif_red;
        logic [15:0] dif_green;
        logic [15:0] dif_blue;
        logic [15:0] shadow_now;
    } levels_t;

    localparam pc_t PC_DIV   = 5'd5;
    localparam pc_t PC_LEVEL = 5'd6;
    localparam pc_t PC_ARM   = 5'd16;
    localparam pc_t PC_NOCHG = 5'd17;

    function automatic uword_t mk(cond_t cond, pc_t target, uop_t uop, src_t src,
                                  dst_t dst, logic emit, logic changed);
        uword_t w;
        w.cond        = cond;
        w.target      = target;
        w.ctl.uop     = uop;
        w.ctl.src     = src;
        w.ctl.dst     = dst;
        w.ctl.emit    = emit;
        w.ctl.changed = changed;
        return w;
    endfunction

    // The program: dispatch, counter update, serial divide, eight multiply passes.
    function automatic uword_t ucode(pc_t pc);
        uword_t w;
        unique case (pc)
            5'd0:  w = mk(COND_ARM,      PC_ARM,   UOP_NOP,   SRC_RANGE,  DST_NONE,   1'b0, 1'b0);
            5'd1:  w = mk(COND_SKIP,     PC_NOCHG, UOP_NOP,   SRC_RANGE,  DST_NONE,   1'b0, 1'b0);
            5'd2:  w = mk(COND_NEVER,    '0,       UOP_COUNT, SRC_RANGE,  DST_NONE,   1'b0, 1'b0);
            5'd3:  w = mk(COND_END,      PC_NOCHG, UOP_NOP,   SRC_RANGE,  DST_NONE,   1'b0, 1'b0);
            5'd4:  w = mk(COND_KNOWN,    PC_LEVEL, UOP_NOP,   SRC_RANGE,  DST_NONE,   1'b0, 1'b0);
            5'd5:  w = mk(COND_DIV_MORE, PC_DIV,   UOP_DIV,   SRC_RANGE,  DST_NONE,   1'b0, 1'b0);
            5'd6:  w = mk(COND_NEVER,    '0,       UOP_LEVEL, SRC_RANGE,  DST_NONE,   1'b0, 1'b0);
            5'd7:  w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_AMB_R,  DST_RANGE,  1'b0, 1'b0);
            5'd8:  w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_AMB_G,  DST_AMB_R,  1'b0, 1'b0);
            5'd9:  w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_AMB_B,  DST_AMB_G,  1'b0, 1'b0);
            5'd10: w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_DIF_R,  DST_AMB_B,  1'b0, 1'b0);
            5'd11: w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_DIF_G,  DST_DIF_R,  1'b0, 1'b0);
            5'd12: w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_DIF_B,  DST_DIF_G,  1'b0, 1'b0);
            5'd13: w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_SHADOW, DST_DIF_B,  1'b0, 1'b0);
            5'd14: w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_RANGE,  DST_SHADOW, 1'b0, 1'b0);
            5'd15: w = mk(COND_NEVER,    '0,       UOP_NOP,   SRC_RANGE,  DST_NONE,   1'b1, 1'b1);
            5'd16: w = mk(COND_NEVER,    '0,       UOP_ARM,   SRC_RANGE,  DST_NONE,   1'b0, 1'b0);
            default: w = mk(COND_NEVER,  '0,       UOP_NOP,   SRC_RANGE,  DST_NONE,   1'b1, 1'b0);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/fade_in_out_envelope.sv @@
// Top level of the fade-in/out envelope: stream channels, output register, assertions.
// Depends on fioe_pkg, fioe_sequencer and fioe_datapath.
//
// Usage: registers are written through cfg_we/cfg_index/cfg_data while the block is idle.
// Each item on the s_ side is either an arm command (tuser 0) or a frame tick (tuser 1);
// every item gives exactly one result item on the m_ side with the held envelope levels.
// The block works on one item at a time; s_tready is high whenever no item is in work.
// An arm loads the counters and then emits; a disabled tick or a repeated logic frame
// emits without further work; the tick that ends the decay stops after the counter update;
// a tick whose factor is settled without a divide makes the eight passes through the
// single shared 16x17 multiplier; a tick that divides first runs the 16-step restoring
// divider and then makes those passes.
// After reset the block is disabled, the level is one and shadow strength is full;
// a tick before the first arm returns the held values with changed low.
// When the receiver stalls, a finished result waits in the output register and the
// sequencer holds on its final step until the register frees; no result is dropped.
`timescale 1ns / 1ps

module fade_in_out_envelope
    import fioe_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // frame_number[31:0], frame_known[32], zero fill
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // level, range_now, amb_red, amb_green, amb_blue,
                                    // dif_red, dif_green, dif_blue, shadow_now, zero fill
    output logic [1:0]   m_tuser,   // active, changed
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    logic           start;
    logic           out_free;
    logic           emit_fire;
    logic           busy;
    ctl_t           ctl;
    stat_t          stat;
    levels_t        lv;
    logic           out_valid_reg;
    logic [151:0]   out_data_reg;
    logic [1:0]     out_user_reg;

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    fioe_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .out_free  (out_free),
        .stat      (stat),
        .ctl       (ctl),
        .emit_fire (emit_fire),
        .busy      (busy)
    );

    fioe_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .in_op     (s_tuser),
        .in_frame  (s_tdata[31:0]),
        .in_known  (s_tdata[32]),
        .ctl       (ctl),
        .stat      (stat),
        .lv        (lv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= {7'b0, lv.shadow_now, lv.dif_blue, lv.dif_green, lv.dif_red,
                             lv.amb_blue, lv.amb_green, lv.amb_red, lv.range_now, lv.level};
            out_user_reg <= {ctl.changed, lv.running};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was still in work");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(busy))
        else $error("result appeared without an item in work");

    a_changed_means_active: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("recomputed result reports a disabled block");

endmodule

@@ rtl/fioe_sequencer.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fioe_pkg for the control word layout and the program table.
`timescale 1ns / 1ps

module fioe_sequencer
    import fioe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  out_free,
    input  stat_t stat,
    output ctl_t  ctl,
    output logic  emit_fire,
    output logic  busy
);

    logic   busy_reg;
    logic   busy_next;
    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;
    logic   take;

    assign uw = ucode(pc_reg);

    always_comb
    begin
        case (uw.cond)
            COND_ARM:      take = stat.arm;
            COND_SKIP:     take = stat.skip;
            COND_END:      take = stat.fin;
            COND_KNOWN:    take = stat.known;
            COND_DIV_MORE: take = stat.div_more;
            default:       take = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end
        else if (uw.ctl.emit)
        begin
            if (out_free)
            begin
                busy_next = 1'b0;
                pc_next   = '0;
            end
        end
        else
        begin
            pc_next = take ? uw.target : pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctl       = busy_reg ? uw.ctl : ctl_t'('0);
    assign emit_fire = busy_reg && uw.ctl.emit && out_free;
    assign busy      = busy_reg;

endmodule

@@ rtl/fioe_datapath.sv @@
// Envelope datapath: configuration registers, counters, serial divider and shared multiplier.
// Depends on fioe_pkg; steered each cycle by the control word of fioe_sequencer.
`timescale 1ns / 1ps

module fioe_datapath
    import fioe_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        start,
    input  logic        in_op,
    input  logic [31:0] in_frame,
    input  logic        in_known,
    input  ctl_t        ctl,
    output stat_t       stat,
    output levels_t     lv
);

    localparam int W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [15:0] rise_frames_reg;
    logic [15:0] fall_frames_reg;
    logic [2:0]  mode_reg;
    logic [15:0] full_range_reg;
    logic [15:0] min_range_reg;
    logic [47:0] full_ambient_reg;
    logic [47:0] full_diffuse_reg;
    logic [15:0] full_shadow_reg;

    logic                  running_reg;
    logic [COUNT_BITS-1:0] rise_left_reg;
    logic [COUNT_BITS-1:0] fall_left_reg;
    logic [31:0]           last_frame_reg;
    logic [16:0]           level_reg;
    logic [15:0]           range_reg;
    logic [47:0]           ambient_reg;
    logic [47:0]           diffuse_reg;
    logic [15:0]           shadow_reg;
    logic                  known_f_reg;
    logic                  fin_reg;

    logic        op_reg;
    logic [31:0] frame_reg;
    logic        known_reg;
    logic [16:0] fac_reg;
    logic [15:0] rem_reg;
    logic [15:0] den_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] prod_reg;

    logic                  gate_hit;
    logic                  rise_case;
    logic [W-1:0]          rf_w;
    logic [W-1:0]          ff_w;
    logic [COUNT_BITS-1:0] nl;
    logic [COUNT_BITS-1:0] nf;
    logic [W-1:0]          nl_w;
    logic [W-1:0]          nf_w;
    logic [W-1:0]          diff_w;
    logic [16:0]           c_fac;
    logic                  c_known;
    logic                  c_fin;
    logic [15:0]           c_rem;
    logic [15:0]           c_den;
    logic [16:0]           rem2;
    logic [16:0]           rem_sub;
    logic                  ge;
    logic [15:0]           mul_v;
    logic [32:0]           mul_full;

    assign gate_hit  = mode_reg[2] && known_reg;
    assign rise_case = (rise_left_reg != '0) && (rise_frames_reg != '0);
    assign rf_w      = W'(rise_frames_reg);
    assign ff_w      = W'(fall_frames_reg);
    assign nl        = rise_left_reg - 1'b1;
    assign nf        = fall_left_reg - 1'b1;
    assign nl_w      = W'(nl);
    assign nf_w      = W'(nf);
    assign diff_w    = rf_w - nl_w;

    // Factor setup: either the factor is settled here, or the ratio goes to the divider.
    always_comb
    begin
        c_known = 1'b1;
        c_fin   = 1'b0;
        c_fac   = ONE_Q16;
        c_rem   = diff_w[15:0];
        c_den   = rise_frames_reg;
        if (rise_case)
        begin
            if (rf_w >= nl_w)
            begin
                if (nl != '0)
                begin
                    c_fac   = '0;
                    c_known = 1'b0;
                end
            end
            else
            begin
                c_fac = '0;
            end
        end
        else if (fall_frames_reg != '0)
        begin
            c_rem = nf_w[15:0];
            c_den = fall_frames_reg;
            if (nf == '0)
            begin
                c_fin = 1'b1;
            end
            else if (nf_w < ff_w)
            begin
                c_fac   = '0;
                c_known = 1'b0;
            end
        end
    end

    assign rem2    = {rem_reg, 1'b0};
    assign rem_sub = rem2 - {1'b0, den_reg};
    assign ge      = rem2 >= {1'b0, den_reg};

    always_comb
    begin
        case (ctl.src)
            SRC_RANGE:  mul_v = full_range_reg;
            SRC_AMB_R:  mul_v = full_ambient_reg[47:32];
            SRC_AMB_G:  mul_v = full_ambient_reg[31:16];
            SRC_AMB_B:  mul_v = full_ambient_reg[15:0];
            SRC_DIF_R:  mul_v = full_diffuse_reg[47:32];
            SRC_DIF_G:  mul_v = full_diffuse_reg[31:16];
            SRC_DIF_B:  mul_v = full_diffuse_reg[15:0];
            SRC_SHADOW: mul_v = full_shadow_reg;
            default:    mul_v = '0;
        endcase
    end

    assign mul_full = 33'(mul_v) * 33'(fac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_frames_reg  <= '0;
            fall_frames_reg  <= '0;
            mode_reg         <= '0;
            full_range_reg   <= '0;
            min_range_reg    <= '0;
            full_ambient_reg <= '0;
            full_diffuse_reg <= '0;
            full_shadow_reg  <= SHADOW_RESET;
            running_reg      <= 1'b0;
            rise_left_reg    <= '0;
            fall_left_reg    <= '0;
            last_frame_reg   <= FRAME_NONE;
            level_reg        <= ONE_Q16;
            range_reg        <= '0;
            ambient_reg      <= '0;
            diffuse_reg      <= '0;
            shadow_reg       <= SHADOW_RESET;
            known_f_reg      <= 1'b1;
            fin_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RISE:    rise_frames_reg  <= cfg_data[15:0];
                    REG_FALL:    fall_frames_reg  <= cfg_data[15:0];
                    REG_MODE:    mode_reg         <= cfg_data[2:0];
                    REG_RANGE:   full_range_reg   <= cfg_data[15:0];
                    REG_MIN:     min_range_reg    <= cfg_data[15:0];
                    REG_AMBIENT: full_ambient_reg <= cfg_data;
                    REG_DIFFUSE: full_diffuse_reg <= cfg_data;
                    REG_SHADOW:  full_shadow_reg  <= cfg_data[15:0];
                endcase
            end

            unique case (ctl.uop)
                UOP_ARM:
                begin
                    rise_left_reg  <= rf_w[COUNT_BITS-1:0];
                    fall_left_reg  <= ff_w[COUNT_BITS-1:0];
                    last_frame_reg <= FRAME_NONE;
                    running_reg    <= 1'b1;
                end
                UOP_COUNT:
                begin
                    if (gate_hit)
                    begin
                        last_frame_reg <= frame_reg;
                    end
                    if (rise_case)
                    begin
                        rise_left_reg <= nl;
                    end
                    else if (fall_frames_reg != '0)
                    begin
                        fall_left_reg <= nf;
                    end
                    if (c_fin)
                    begin
                        running_reg <= 1'b0;
                    end
                    known_f_reg <= c_known;
                    fin_reg     <= c_fin;
                end
                UOP_LEVEL:
                begin
                    level_reg <= fac_reg;
                end
                default:
                begin
                end
            endcase

            unique case (ctl.dst)
                DST_RANGE:
                begin
                    if (mode_reg[0])
                    begin
                        range_reg <= (prod_reg < min_range_reg) ? min_range_reg : prod_reg;
                    end
                end
                DST_AMB_R:  if (mode_reg[1]) ambient_reg[47:32] <= prod_reg;
                DST_AMB_G:  if (mode_reg[1]) ambient_reg[31:16] <= prod_reg;
                DST_AMB_B:  if (mode_reg[1]) ambient_reg[15:0]  <= prod_reg;
                DST_DIF_R:  if (mode_reg[1]) diffuse_reg[47:32] <= prod_reg;
                DST_DIF_G:  if (mode_reg[1]) diffuse_reg[31:16] <= prod_reg;
                DST_DIF_B:  if (mode_reg[1]) diffuse_reg[15:0]  <= prod_reg;
                DST_SHADOW: if (mode_reg[1]) shadow_reg         <= prod_reg;
                default:
                begin
                end
            endcase
        end
    end

    // Input capture, restoring divider (one quotient bit per step, shifted into the factor) and product register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg    <= in_op;
            frame_reg <= in_frame;
            known_reg <= in_known;
        end
        if (ctl.uop == UOP_COUNT)
        begin
            fac_reg <= c_fac;
            rem_reg <= c_rem;
            den_reg <= c_den;
            cnt_reg <= 4'hF;
        end
        else if (ctl.uop == UOP_DIV)
        begin
            rem_reg <= ge ? rem_sub[15:0] : rem2[15:0];
            fac_reg <= {fac_reg[15:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        prod_reg <= mul_full[31:16];
    end

    assign stat.arm      = (op_reg == OP_ARM);
    assign stat.skip     = !running_reg || (gate_hit && (frame_reg == last_frame_reg));
    assign stat.fin      = fin_reg;
    assign stat.known    = known_f_reg;
    assign stat.div_more = (cnt_reg != '0);

    assign lv.running    = running_reg;
    assign lv.level      = level_reg;
    assign lv.range_now  = range_reg;
    assign lv.amb_red    = ambient_reg[47:32];
    assign lv.amb_green  = ambient_reg[31:16];
    assign lv.amb_blue   = ambient_reg[15:0];
    assign lv.dif_red    = diffuse_reg[47:32];
    assign lv.dif_green  = diffuse_reg[31:16];
    assign lv.dif_blue   = diffuse_reg[15:0];
    assign lv.shadow_now = shadow_reg;

endmodule
